>>> hdl/dsfd_pkg.sv
// ----------------------------------------------------------------------------
// dsfd_pkg: shared types and constants for the DLE/STX frame decoder
// Holds the register map, frame phase codes, result codes, the CRC-16/ARC
// nibble tables and the one-byte CRC update function.
// ----------------------------------------------------------------------------
package dsfd_pkg;

    // Fixed header bytes
    localparam logic [7:0] SYN_BYTE = 8'h16;
    localparam logic [7:0] DLE_BYTE = 8'h10;
    localparam logic [7:0] STX_BYTE = 8'h02;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOM_CHAR    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_EN   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FCS_EN      = 8'd3;

    localparam logic [7:0] ESCAPE_RESET = 8'h10;
    localparam logic [7:0] EOM_RESET    = 8'h03;

    // Input transaction kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    // Result kinds
    localparam logic [1:0] RES_DATA  = 2'd0;
    localparam logic [1:0] RES_END   = 2'd1;
    localparam logic [1:0] RES_STATS = 2'd2;

    // Frame end status
    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // Frame phases
    localparam logic [2:0] PH_HUNT_SYN = 3'd0;
    localparam logic [2:0] PH_WAIT_DLE = 3'd1;
    localparam logic [2:0] PH_WAIT_STX = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_ESCAPE   = 3'd4;
    localparam logic [2:0] PH_CRC_LO   = 3'd5;
    localparam logic [2:0] PH_CRC_HI   = 3'd6;
    localparam logic [2:0] PH_UNUSED   = 3'd7;

    localparam logic [31:0] DISCARD_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] escape_char;
        logic [7:0] eom_char;
        logic       header_en;
        logic       fcs_en;
    } cfg_t;

    typedef struct packed {
        logic        vld;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        status;
        logic [31:0] count;
    } result_t;

    // CRC-16/ARC nibble tables (reflected poly 0xA001)
    localparam logic [15:0] CRC_LO_NIB [16] = '{
        16'h0000, 16'hC0C1, 16'hC181, 16'h0140, 16'hC301, 16'h03C0, 16'h0280, 16'hC241,
        16'hC601, 16'h06C0, 16'h0780, 16'hC741, 16'h0500, 16'hC5C1, 16'hC481, 16'h0440
    };
    localparam logic [15:0] CRC_HI_NIB [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    // One byte through the CRC
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] idx;
        idx = crc[7:0] ^ b;
        return {8'h00, crc[15:8]} ^ CRC_LO_NIB[idx[3:0]] ^ CRC_HI_NIB[idx[7:4]];
    endfunction

endpackage

>>> hdl/dle_stx_frame_decoder_crc16_top.sv
// ----------------------------------------------------------------------------
// dle_stx_frame_decoder_crc16_top: DLE/STX deframer with CRC-16/ARC check
// Input register, single-pass decode and a result register with handshake.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | kind, rx_byte
//  output   | out_valid / out_ready | result_kind, data_byte, frame_status,
//           |                       | discard_count
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One transaction per cycle while the output is not stalled; a result goes
//  through the input register, then the decode into the result register,
//  before it is handed over. The state update and CRC byte step sit
//  between the input register and the result register.
//  Reset clears the frame phase, CRC, discard count and the valid flags;
//  configuration returns to DLE/ETX with header and CRC check enabled.
//  A stalled result holds the decode stage; in_ready drops only when both
//  stages are full and out_ready is low. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dle_stx_frame_decoder_crc16_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     result_kind,
    output logic [7:0]                     data_byte,
    output logic                           frame_status,
    output logic [31:0]                    discard_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import dsfd_pkg::*;

    cfg_t       cfg_reg;
    logic       in_vld_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       out_vld_reg, out_vld_next;
    result_t    res;
    result_t    out_reg;
    logic       advance;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_char <= ESCAPE_RESET;
            cfg_reg.eom_char    <= EOM_RESET;
            cfg_reg.header_en   <= 1'b1;
            cfg_reg.fcs_en      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ESCAPE_CHAR: cfg_reg.escape_char <= cfg_data;
                REG_EOM_CHAR:    cfg_reg.eom_char    <= cfg_data;
                REG_HEADER_EN:   cfg_reg.header_en   <= cfg_data[0];
                REG_FCS_EN:      cfg_reg.fcs_en      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Decode stage moves when the result slot is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
    end

    dsfd_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .kind    (kind_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register
    always_comb
    begin
        if (advance)
        begin
            out_vld_next = res.vld;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.vld)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_vld_reg;
    assign result_kind   = out_reg.kind;
    assign data_byte     = out_reg.data;
    assign frame_status  = out_reg.status;
    assign discard_count = out_reg.count;

endmodule

>>> hdl/dsfd_deframer.sv
// ----------------------------------------------------------------------------
// dsfd_deframer: frame state, CRC and discard counter
// Holds the frame phase, the running CRC and the pre-header discard count.
// Decodes the staged transaction in one pass and updates state on step.
// ----------------------------------------------------------------------------
module dsfd_deframer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             kind,
    input  logic [7:0]       rx_byte,
    input  dsfd_pkg::cfg_t   cfg,
    output dsfd_pkg::result_t res
);
    import dsfd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] discards_reg, discards_next;

    logic [2:0]  eff_phase;
    logic [15:0] crc_cur;
    logic [1:0]  add_n;
    logic [32:0] disc_sum;

    // Decode one transaction
    always_comb
    begin
        res           = '0;
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        add_n         = 2'd0;
        discards_next = discards_reg;
        eff_phase     = phase_reg;
        crc_cur       = crc_reg;
        disc_sum      = '0;

        if (kind == KIND_STATS)
        begin
            res.vld       = 1'b1;
            res.kind      = RES_STATS;
            res.count     = discards_reg;
            discards_next = '0;
        end
        else
        begin
            // Hunting: header check, or straight into data when headers are off
            if (phase_reg == PH_HUNT_SYN || phase_reg == PH_UNUSED)
            begin
                crc_cur  = '0;
                crc_next = '0;
                if (cfg.header_en)
                begin
                    eff_phase = PH_HUNT_SYN;
                end
                else
                begin
                    eff_phase = PH_DATA;
                end
            end

            case (eff_phase)
                PH_HUNT_SYN:
                begin
                    if (rx_byte == SYN_BYTE)
                    begin
                        phase_next = PH_WAIT_DLE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT_SYN;
                        add_n      = 2'd1;
                    end
                end
                PH_WAIT_DLE:
                begin
                    if (rx_byte == DLE_BYTE)
                    begin
                        phase_next = PH_WAIT_STX;
                    end
                    else
                    begin
                        phase_next = PH_HUNT_SYN;
                        add_n      = 2'd2;
                    end
                end
                PH_WAIT_STX:
                begin
                    if (rx_byte == STX_BYTE)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT_SYN;
                        add_n      = 2'd3;
                    end
                end
                PH_DATA:
                begin
                    if (rx_byte == cfg.escape_char)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        if (cfg.fcs_en)
                        begin
                            crc_next = crc_step(crc_cur, rx_byte);
                        end
                        res.vld  = 1'b1;
                        res.kind = RES_DATA;
                        res.data = rx_byte;
                    end
                end
                PH_ESCAPE:
                begin
                    if (rx_byte == cfg.eom_char)
                    begin
                        if (cfg.fcs_en)
                        begin
                            crc_next   = crc_step(crc_cur, rx_byte);
                            phase_next = PH_CRC_LO;
                        end
                        else
                        begin
                            phase_next = PH_HUNT_SYN;
                            res.vld    = 1'b1;
                            res.kind   = RES_END;
                            res.status = STATUS_GOOD;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        // Doubled escape gives one data byte; anything else is dropped
                        if (rx_byte == cfg.escape_char)
                        begin
                            if (cfg.fcs_en)
                            begin
                                crc_next = crc_step(crc_cur, rx_byte);
                            end
                            res.vld  = 1'b1;
                            res.kind = RES_DATA;
                            res.data = rx_byte;
                        end
                    end
                end
                PH_CRC_LO:
                begin
                    if (rx_byte == crc_cur[7:0])
                    begin
                        phase_next = PH_CRC_HI;
                    end
                    else
                    begin
                        phase_next = PH_HUNT_SYN;
                        res.vld    = 1'b1;
                        res.kind   = RES_END;
                        res.status = STATUS_BAD;
                    end
                end
                PH_CRC_HI:
                begin
                    phase_next = PH_HUNT_SYN;
                    res.vld    = 1'b1;
                    res.kind   = RES_END;
                    res.status = (rx_byte == crc_cur[15:8]) ? STATUS_GOOD : STATUS_BAD;
                end
                default:
                begin
                    phase_next = PH_HUNT_SYN;
                end
            endcase

            // Saturating discard add
            disc_sum      = {1'b0, discards_reg} + {31'd0, add_n};
            discards_next = disc_sum[32] ? DISCARD_MAX : disc_sum[31:0];
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT_SYN;
            crc_reg      <= '0;
            discards_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            discards_reg <= discards_next;
        end
    end

endmodule

>>> hdl/dsfd_checker.sv
// ----------------------------------------------------------------------------
// dsfd_checker: port-level checks for the frame decoder
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module dsfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [7:0]  data_byte,
    input logic        frame_status,
    input logic [31:0] discard_count
);
    import dsfd_pkg::*;

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid as reset is released");

    // A stalled result stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_kind) && $stable(data_byte)
            && $stable(frame_status) && $stable(discard_count))
        else $error("result payload changed while stalled");

    // Fields that do not belong to the result kind are zero
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_DATA |-> frame_status == 1'b0
            && discard_count == 32'd0)
        else $error("data result carries stray fields");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RES_STATS || result_kind == RES_END)
            |-> data_byte == 8'd0)
        else $error("non-data result carries a data byte");

endmodule

bind dle_stx_frame_decoder_crc16_top dsfd_checker u_dsfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .data_byte     (data_byte),
    .frame_status  (frame_status),
    .discard_count (discard_count)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dle_stx_frame_decoder_crc16_top
// Drives line bytes and statistics commands through the input handshake and
// mirrors the deframer in a local model. The model covers header hunting,
// un-escaping, the CRC-16/ARC trailer check and the discard counter. Each
// result transaction is checked field by field against the oldest prediction.
// Traffic is a short directed part, then well-formed frames with random
// content mixed with noise, broken headers and corrupt trailers. The runs use
// several register settings and several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    import dsfd_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_MARGIN = 6;
    localparam int unsigned MAX_GAP      = 30;
    localparam int unsigned HOLD_CYCLES  = 300;

    // Ways of spoiling a generated frame
    typedef enum logic [1:0] {
        FRM_CLEAN,
        FRM_BAD_CRC_LO,
        FRM_BAD_CRC_HI,
        FRM_STRAY_ESCAPE
    } frame_fault_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        status;
        logic [31:0] count;
    } decode_t;

    // DUT connections
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 kind          = KIND_BYTE;
    logic [7:0]           rx_byte       = 8'h00;
    logic                 out_valid;
    logic                 out_ready     = 1'b1;
    logic [1:0]           result_kind;
    logic [7:0]           data_byte;
    logic                 frame_status;
    logic [31:0]          discard_count;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_ESCAPE_CHAR;
    logic [7:0]           cfg_data      = 8'h00;

    // Local copy of the deframer registers and state
    logic [7:0]  cfg_esc     = ESCAPE_RESET;
    logic [7:0]  cfg_eom     = EOM_RESET;
    logic        cfg_hdr     = 1'b1;
    logic        cfg_fcs     = 1'b1;
    logic [2:0]  phase_q     = PH_HUNT_SYN;
    logic [15:0] crc_q       = 16'h0000;
    logic [31:0] discards_q  = 32'h0;

    decode_t     awaited_decodes[$];

    int unsigned snd_idle_pct    = 0;
    int unsigned rcv_stall_pct   = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned items_sent      = 0;
    int unsigned cycle_count     = 0;
    int unsigned fail_count      = 0;

    dle_stx_frame_decoder_crc16_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .data_byte     (data_byte),
        .frame_status  (frame_status),
        .discard_count (discard_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // CRC-16/ARC, one byte, bit-serial (reflected poly 0xA001)
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        repeat (8)
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        return x;
    endfunction

    // Saturating add to the pre-header discard count
    function automatic void count_discards(input logic [31:0] n);
        if (discards_q > DISCARD_MAX - n)
            discards_q = DISCARD_MAX;
        else
            discards_q = discards_q + n;
    endfunction

    // One accepted transaction through the deframer; returns 1 with a result
    function automatic bit deframe_step(input logic k, input logic [7:0] b,
                                        output decode_t r);
        logic [2:0] ph;
        r        = '0;
        r.kind   = RES_DATA;
        r.status = STATUS_GOOD;
        if (k == KIND_STATS)
        begin
            r.kind     = RES_STATS;
            r.count    = discards_q;
            discards_q = '0;
            return 1'b1;
        end
        ph = phase_q;
        // hunting: header bytes, or straight into data when the header is off
        if (ph == PH_HUNT_SYN || ph == PH_UNUSED)
        begin
            crc_q = '0;
            if (cfg_hdr)
            begin
                if (b == SYN_BYTE)
                    phase_q = PH_WAIT_DLE;
                else
                begin
                    phase_q = PH_HUNT_SYN;
                    count_discards(1);
                end
                return 1'b0;
            end
            ph = PH_DATA;
        end
        case (ph)
            PH_WAIT_DLE:
            begin
                if (b == DLE_BYTE)
                    phase_q = PH_WAIT_STX;
                else
                begin
                    phase_q = PH_HUNT_SYN;
                    count_discards(2);
                end
                return 1'b0;
            end
            PH_WAIT_STX:
            begin
                if (b == STX_BYTE)
                    phase_q = PH_DATA;
                else
                begin
                    phase_q = PH_HUNT_SYN;
                    count_discards(3);
                end
                return 1'b0;
            end
            PH_DATA:
            begin
                if (b == cfg_esc)
                begin
                    phase_q = PH_ESCAPE;
                    return 1'b0;
                end
                phase_q = PH_DATA;
                if (cfg_fcs)
                    crc_q = crc16_arc_byte(crc_q, b);
                r.data = b;
                return 1'b1;
            end
            PH_ESCAPE:
            begin
                // end of message wins over a doubled escape
                if (b == cfg_eom)
                begin
                    if (cfg_fcs)
                    begin
                        crc_q   = crc16_arc_byte(crc_q, b);
                        phase_q = PH_CRC_LO;
                        return 1'b0;
                    end
                    phase_q = PH_HUNT_SYN;
                    r.kind  = RES_END;
                    return 1'b1;
                end
                phase_q = PH_DATA;
                if (b == cfg_esc)
                begin
                    if (cfg_fcs)
                        crc_q = crc16_arc_byte(crc_q, b);
                    r.data = b;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_CRC_LO:
            begin
                if (b == crc_q[7:0])
                begin
                    phase_q = PH_CRC_HI;
                    return 1'b0;
                end
                phase_q  = PH_HUNT_SYN;
                r.kind   = RES_END;
                r.status = STATUS_BAD;
                return 1'b1;
            end
            default:
            begin
                phase_q  = PH_HUNT_SYN;
                r.kind   = RES_END;
                r.status = (b == crc_q[15:8]) ? STATUS_GOOD : STATUS_BAD;
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One input transaction, with a random idle gap ahead of it
    task automatic send_item(input logic k, input logic [7:0] b);
        int unsigned gap;
        decode_t     res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (deframe_step(k, b, res))
            awaited_decodes.push_back(res);
    endtask

    // Sender goes quiet until every predicted result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_MARGIN) @(posedge clk);
    endtask

    // One register write transaction; cfg_valid is left high for the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ESCAPE_CHAR: cfg_esc = v;
            REG_EOM_CHAR:    cfg_eom = v;
            REG_HEADER_EN:   cfg_hdr = v[0];
            REG_FCS_EN:      cfg_fcs = v[0];
            default:         ;
        endcase
    endtask

    // Full register set, written only once the block has gone idle
    task automatic set_config(input logic [7:0] esc, input logic [7:0] eom,
                              input logic hdr, input logic fcs);
        logic [7:0] v;
        wait_drained();
        write_reg(REG_ESCAPE_CHAR, esc);
        write_reg(REG_EOM_CHAR, eom);
        // upper bits of the one-bit registers must be ignored
        v    = 8'($urandom);
        v[0] = hdr;
        write_reg(REG_HEADER_EN, v);
        v    = 8'($urandom);
        v[0] = fcs;
        write_reg(REG_FCS_EN, v);
        if ($urandom_range(1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_FCS_EN + 1)),
                      8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Line byte biased towards the characters the decoder reacts to
    function automatic logic [7:0] pick_line_byte();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(11))
            0:       v = cfg_esc;
            1:       v = cfg_eom;
            2:       v = SYN_BYTE;
            default: ;
        endcase
        return v;
    endfunction

    // A framed message under the current settings, optionally spoilt
    task automatic send_frame(input int unsigned len, input frame_fault_e fault);
        logic [15:0] fcs;
        logic [7:0]  b;
        logic [7:0]  o;
        int unsigned stray_at;
        int unsigned i;
        fcs      = '0;
        stray_at = (fault == FRM_STRAY_ESCAPE) ? $urandom_range(len) : len + 1;
        if (cfg_hdr)
        begin
            send_item(KIND_BYTE, SYN_BYTE);
            send_item(KIND_BYTE, DLE_BYTE);
            send_item(KIND_BYTE, STX_BYTE);
        end
        for (i = 0; i < len; i++)
        begin
            // escape plus an ordinary byte: both vanish from the payload
            if (i == stray_at)
            begin
                do
                    o = 8'($urandom);
                while (o == cfg_esc || o == cfg_eom);
                send_item(KIND_BYTE, cfg_esc);
                send_item(KIND_BYTE, o);
            end
            if ($urandom_range(49) == 0)
                send_item(KIND_STATS, 8'($urandom));
            b = pick_line_byte();
            if (b == cfg_esc)
                send_item(KIND_BYTE, cfg_esc);
            send_item(KIND_BYTE, b);
            fcs = crc16_arc_byte(fcs, b);
        end
        send_item(KIND_BYTE, cfg_esc);
        send_item(KIND_BYTE, cfg_eom);
        fcs = crc16_arc_byte(fcs, cfg_eom);
        if (cfg_fcs)
        begin
            b = fcs[7:0];
            if (fault == FRM_BAD_CRC_LO)
                b = b ^ 8'($urandom_range(255, 1));
            send_item(KIND_BYTE, b);
            b = fcs[15:8];
            if (fault == FRM_BAD_CRC_HI)
                b = b ^ 8'($urandom_range(255, 1));
            send_item(KIND_BYTE, b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always
    begin
        @(posedge clk);
        if (hold_off_cycles != 0)
        begin
            out_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clk);
            hold_off_cycles = 0;
        end
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        decode_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_decodes.size() == 0)
            begin
                $display("%0t: expected none, actual kind %0d data %0h status %0d count %0d",
                         $time, result_kind, data_byte, frame_status, discard_count);
                fail_count++;
            end
            else
            begin
                want = awaited_decodes.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("data_byte", 32'(want.data), 32'(data_byte));
                check_field("frame_status", 32'(want.status), 32'(frame_status));
                check_field("discard_count", want.count, discard_count);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached, %0d results outstanding",
                     $time, awaited_decodes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Good frame at reset settings: byte extremes, doubled and stray escapes
    task automatic test_clean_frame();
        logic [15:0] fcs;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        set_config(ESCAPE_RESET, EOM_RESET, 1'b1, 1'b1);
        fcs = crc16_arc_byte(crc16_arc_byte(16'h0000, 8'h00), 8'hFF);
        fcs = crc16_arc_byte(crc16_arc_byte(fcs, ESCAPE_RESET), EOM_RESET);
        send_item(KIND_BYTE, SYN_BYTE);
        send_item(KIND_BYTE, DLE_BYTE);
        send_item(KIND_BYTE, STX_BYTE);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, 8'h55);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, EOM_RESET);
        send_item(KIND_BYTE, fcs[7:0]);
        send_item(KIND_BYTE, fcs[15:8]);
    endtask

    // Noise and both kinds of broken header, then a statistics read
    task automatic test_header_faults();
        send_item(KIND_BYTE, 8'hAA);
        send_item(KIND_BYTE, SYN_BYTE);
        send_item(KIND_BYTE, 8'h99);
        send_item(KIND_BYTE, SYN_BYTE);
        send_item(KIND_BYTE, DLE_BYTE);
        send_item(KIND_BYTE, 8'h77);
        send_item(KIND_STATS, 8'hFF);
    endtask

    // Receiver holds off for a long stretch while frames keep coming
    task automatic test_backpressure();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        set_config(ESCAPE_RESET, EOM_RESET, 1'b1, 1'b1);
        hold_off_cycles = HOLD_CYCLES;
        repeat (4) send_frame(24, FRM_CLEAN);
        wait_drained();
    endtask

    // Mixed traffic over two register settings per idle pattern
    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input int unsigned n_items);
        static int unsigned cfg_round = 0;
        int unsigned  seg;
        int unsigned  target;
        int unsigned  sel;
        int unsigned  len;
        logic [7:0]   e;
        logic [7:0]   m;
        frame_fault_e fault;
        for (seg = 0; seg < 2; seg++)
        begin
            e = 8'($urandom);
            m = 8'($urandom);
            case (cfg_round % 8)
                0:       set_config(ESCAPE_RESET, EOM_RESET, 1'b0, 1'b1);
                1:       set_config(8'h00, 8'hFF, 1'b1, 1'b0);
                2:       set_config(8'hFF, 8'h00, 1'b0, 1'b0);
                3:       set_config(e, m, 1'b1, 1'b1);
                4:       set_config(ESCAPE_RESET, EOM_RESET, 1'b1, 1'b1);
                // escape and end-of-message the same character
                5:       set_config(e, e, 1'b1, 1'b1);
                6:       set_config(e, m, 1'b0, 1'b1);
                default: set_config(SYN_BYTE, STX_BYTE, 1'b1, 1'b1);
            endcase
            cfg_round++;
            snd_idle_pct  = snd_pct;
            rcv_stall_pct = rcv_pct;
            target        = items_sent + n_items / 2;
            while (items_sent < target)
            begin
                sel = $urandom_range(99);
                if (sel < 72)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(10);
                    case ($urandom_range(19))
                        0, 1:    fault = FRM_BAD_CRC_LO;
                        2, 3:    fault = FRM_BAD_CRC_HI;
                        4, 5:    fault = FRM_STRAY_ESCAPE;
                        default: fault = FRM_CLEAN;
                    endcase
                    send_frame(len, fault);
                end
                else if (sel < 84)
                    repeat ($urandom_range(4, 1)) send_item(KIND_BYTE, pick_line_byte());
                else if (sel < 92)
                begin
                    // header cut short after SYN or after SYN DLE
                    send_item(KIND_BYTE, SYN_BYTE);
                    if ($urandom_range(1) == 1)
                    begin
                        send_item(KIND_BYTE, DLE_BYTE);
                        send_item(KIND_BYTE, pick_line_byte());
                    end
                    else
                        send_item(KIND_BYTE, pick_line_byte());
                end
                else
                    send_item(KIND_STATS, 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_clean_frame();
        test_header_faults();
        test_backpressure();
        test_random_traffic(0, 0, 390);
        test_random_traffic(65, 0, 390);
        test_random_traffic(0, 65, 390);
        test_random_traffic(15, 15, 390);
        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/dsfd_pkg.sv
hdl/dsfd_deframer.sv
hdl/dle_stx_frame_decoder_crc16_top.sv
hdl/dsfd_checker.sv
tb/sv/testbench.sv
